### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the heap allocator RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Checked while reset is released.
`define ILA_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
// Checked at every edge, reset included.
`define ILA_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ILA_ASSERT(lbl, clk, rstn, prop)
`define ILA_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

### rtl/core/ila_pkg.sv
// ----------------------------------------------------------------------------
// ila_pkg
// Types and fixed constants of the implicit-list heap allocator.
// ----------------------------------------------------------------------------
package ila_pkg;

  localparam int unsigned CHUNK_W     = 17;
  localparam int unsigned REQ_W       = 16;
  localparam int unsigned ADDR_W      = 16;
  localparam int unsigned GROW_W      = 18;
  localparam int unsigned CHUNK_RESET = 4096;
  localparam int unsigned TAG_BYTES   = 16;
  localparam int unsigned MIN_SPLIT   = 24;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [4:0] {
    S_INIT_PRO, S_INIT_HDR, S_INIT_FTR, S_INIT_EPI,
    S_IDLE, S_DISPATCH, S_WALK_RD, S_WALK_CHK,
    S_FREE_WH, S_FREE_WF,
    S_GROW, S_GROW_WH, S_GROW_WF, S_GROW_WE,
    S_M_PF, S_M_PH, S_M_NH, S_M_CALC, S_M_WH, S_M_WF,
    S_CARVE, S_C_WF, S_C_SF, S_C_SRH, S_C_SRF,
    S_RESP_OK, S_RESP_NULL
  } ila_state_e;

  typedef enum logic [4:0] {
    DP_NONE,
    DP_INIT_PRO, DP_INIT_HDR, DP_INIT_FTR, DP_INIT_EPI,
    DP_LOAD, DP_RD_B, DP_STEP, DP_TAKE,
    DP_WR_HDR_FREE, DP_WR_FTR_FREE, DP_WR_HDR_USED, DP_WR_FTR_USED, DP_WR_EPI,
    DP_GROW, DP_RD_PF, DP_RD_PH, DP_RD_NH, DP_MCALC,
    DP_SPL_H, DP_SPL_F, DP_SPL_RH, DP_SPL_RF,
    DP_RESP_OK, DP_RESP_NULL
  } dp_cmd_e;

  typedef struct packed {
    logic is_free;
    logic req_zero;
    logic addr_zero;
    logic at_end;
    logic size_zero;
    logic fit;
    logic used;
    logic hit;
    logic past;
    logic split;
    logic no_room;
    logic both_used;
    logic out_free;
  } dp_status_t;

endpackage

### rtl/core/ila_ifs.sv
// ----------------------------------------------------------------------------
// ila_req_if / ila_rsp_if
// Valid/ready channels carrying allocator requests and results.
// ----------------------------------------------------------------------------
interface ila_req_if;
  import ila_pkg::*;
  logic               valid;
  logic               ready;
  logic               op;
  logic [REQ_W-1:0]   req_size;
  logic [ADDR_W-1:0]  block_addr;
  modport source (output valid, op, req_size, block_addr, input ready);
  modport sink   (input valid, op, req_size, block_addr, output ready);
endinterface

interface ila_rsp_if;
  import ila_pkg::*;
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] payload_addr;
  logic              granted;
  modport source (output valid, payload_addr, granted, input ready);
  modport sink   (input valid, payload_addr, granted, output ready);
endinterface

### rtl/core/implicit_list_heap_allocator_core.sv
// ----------------------------------------------------------------------------
// implicit_list_heap_allocator_core
// First-fit boundary-tag heap allocator with allocate and free requests.
// ----------------------------------------------------------------------------
// Requests arrive as items on req_i (op 0 allocates req_size bytes, op 1
// frees the payload at block_addr); exactly one result item per request
// leaves on rsp_o with the granted payload offset, or zero with granted low.
// chunk_size is written through cfg_we_i/cfg_wdata_i; the user must write it
// only while the block is idle, which the block itself does not enforce.
// After reset the controller writes the prologue, the first free chunk and
// the epilogue into the heap store; no request is taken during that time, and
// the rest of the store is never read before written. One request is handled
// at a time, through the one-write, one-read heap word store: every block
// visited in the first-fit or free walk is a header read, then a check, and
// the longest request is a grow followed by a merge and a split. The result
// sits in an output register; if the receiver stalls the block still accepts
// and works on the next request and only waits when that next result is
// ready to be loaded.
module implicit_list_heap_allocator_core #(
  parameter int unsigned HEAP_BYTES = 65536
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [ila_pkg::CHUNK_W-1:0]  cfg_wdata_i,
  ila_req_if.sink                      req_i,
  ila_rsp_if.source                    rsp_o
);
  import ila_pkg::*;
  `include "assert_macros.svh"

  dp_cmd_e    cmd;
  dp_status_t st;

  // The sequencer owns the request handshake; the datapath owns the result.
  ila_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .st_i        (st),
    .cmd_o       (cmd)
  );

  ila_dp #(.HEAP_BYTES(HEAP_BYTES)) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .st_o           (st),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .op_i           (req_i.op),
    .req_size_i     (req_i.req_size),
    .block_addr_i   (req_i.block_addr),
    .rsp_ready_i    (rsp_o.ready),
    .rsp_valid_o    (rsp_o.valid),
    .payload_addr_o (rsp_o.payload_addr),
    .granted_o      (rsp_o.granted)
  );

  // Only one request is in work, so ready drops right after an accept.
  `ILA_ASSERT(a_one_in_work, clk_i, rst_ni, req_i.valid && req_i.ready |=> !req_i.ready)
  // Granted payloads follow a header on an 8-byte boundary.
  `ILA_ASSERT(a_grant_aligned, clk_i, rst_ni, rsp_o.valid && rsp_o.granted |-> rsp_o.payload_addr[2:0] == 3'd0)
  // A refused or free result never carries an offset.
  `ILA_ASSERT(a_null_zero, clk_i, rst_ni, rsp_o.valid && !rsp_o.granted |-> rsp_o.payload_addr == '0)
endmodule

### rtl/core/ila_ram.sv
// ----------------------------------------------------------------------------
// ila_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ila_ram #(
  parameter int unsigned WIDTH = 18,
  parameter int unsigned DEPTH = 8192
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

### rtl/core/ila_ctrl.sv
// ----------------------------------------------------------------------------
// ila_ctrl
// Sequencer that walks, splits, grows and merges heap blocks.
// ----------------------------------------------------------------------------
module ila_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  output logic                req_ready_o,
  input  ila_pkg::dp_status_t st_i,
  output ila_pkg::dp_cmd_e    cmd_o
);
  import ila_pkg::*;

  ila_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT_PRO;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = DP_NONE;
    req_ready_o = 1'b0;
    case (state_q)
      S_INIT_PRO: begin cmd_o = DP_INIT_PRO; state_d = S_INIT_HDR; end
      S_INIT_HDR: begin cmd_o = DP_INIT_HDR; state_d = S_INIT_FTR; end
      S_INIT_FTR: begin cmd_o = DP_INIT_FTR; state_d = S_INIT_EPI; end
      S_INIT_EPI: begin cmd_o = DP_INIT_EPI; state_d = S_IDLE; end
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o   = DP_LOAD;
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (st_i.is_free) begin
          state_d = st_i.addr_zero ? S_RESP_NULL : S_WALK_RD;
        end else begin
          state_d = st_i.req_zero ? S_RESP_NULL : S_WALK_RD;
        end
      end
      S_WALK_RD: begin
        if (st_i.at_end) begin
          state_d = st_i.is_free ? S_RESP_NULL : S_GROW;
        end else begin
          cmd_o   = DP_RD_B;
          state_d = S_WALK_CHK;
        end
      end
      S_WALK_CHK: begin
        if (st_i.is_free) begin
          if (st_i.size_zero) begin
            state_d = S_RESP_NULL;
          end else if (st_i.hit) begin
            if (st_i.used) begin
              cmd_o   = DP_TAKE;
              state_d = S_FREE_WH;
            end else begin
              state_d = S_RESP_NULL;
            end
          end else if (st_i.past) begin
            state_d = S_RESP_NULL;
          end else begin
            cmd_o   = DP_STEP;
            state_d = S_WALK_RD;
          end
        end else begin
          if (st_i.size_zero) begin
            state_d = S_GROW;
          end else if (st_i.fit) begin
            cmd_o   = DP_TAKE;
            state_d = S_CARVE;
          end else begin
            cmd_o   = DP_STEP;
            state_d = S_WALK_RD;
          end
        end
      end
      S_FREE_WH: begin cmd_o = DP_WR_HDR_FREE; state_d = S_FREE_WF; end
      S_FREE_WF: begin cmd_o = DP_WR_FTR_FREE; state_d = S_M_PF; end
      S_GROW: begin
        if (st_i.no_room) begin
          state_d = S_RESP_NULL;
        end else begin
          cmd_o   = DP_GROW;
          state_d = S_GROW_WH;
        end
      end
      S_GROW_WH: begin cmd_o = DP_WR_HDR_FREE; state_d = S_GROW_WF; end
      S_GROW_WF: begin cmd_o = DP_WR_FTR_FREE; state_d = S_GROW_WE; end
      S_GROW_WE: begin cmd_o = DP_WR_EPI;      state_d = S_M_PF; end
      S_M_PF:    begin cmd_o = DP_RD_PF;       state_d = S_M_PH; end
      S_M_PH:    begin cmd_o = DP_RD_PH;       state_d = S_M_NH; end
      S_M_NH:    begin cmd_o = DP_RD_NH;       state_d = S_M_CALC; end
      S_M_CALC: begin
        cmd_o = DP_MCALC;
        if (st_i.both_used) begin
          state_d = st_i.is_free ? S_RESP_NULL : S_CARVE;
        end else begin
          state_d = S_M_WH;
        end
      end
      S_M_WH: begin cmd_o = DP_WR_HDR_FREE; state_d = S_M_WF; end
      S_M_WF: begin
        cmd_o   = DP_WR_FTR_FREE;
        state_d = st_i.is_free ? S_RESP_NULL : S_CARVE;
      end
      S_CARVE: begin
        if (st_i.split) begin
          cmd_o   = DP_SPL_H;
          state_d = S_C_SF;
        end else begin
          cmd_o   = DP_WR_HDR_USED;
          state_d = S_C_WF;
        end
      end
      S_C_WF:  begin cmd_o = DP_WR_FTR_USED; state_d = S_RESP_OK; end
      S_C_SF:  begin cmd_o = DP_SPL_F;       state_d = S_C_SRH; end
      S_C_SRH: begin cmd_o = DP_SPL_RH;      state_d = S_C_SRF; end
      S_C_SRF: begin cmd_o = DP_SPL_RF;      state_d = S_RESP_OK; end
      S_RESP_OK: begin
        if (st_i.out_free) begin
          cmd_o   = DP_RESP_OK;
          state_d = S_IDLE;
        end
      end
      S_RESP_NULL: begin
        if (st_i.out_free) begin
          cmd_o   = DP_RESP_NULL;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end
endmodule

### rtl/core/ila_dp.sv
// ----------------------------------------------------------------------------
// ila_dp
// Heap word store, block pointer registers and the result register.
// ----------------------------------------------------------------------------
module ila_dp #(
  parameter int unsigned HEAP_BYTES = 65536
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ila_pkg::dp_cmd_e              cmd_i,
  output ila_pkg::dp_status_t           st_o,
  input  logic                          cfg_we_i,
  input  logic [ila_pkg::CHUNK_W-1:0]   cfg_wdata_i,
  input  logic                          op_i,
  input  logic [ila_pkg::REQ_W-1:0]     req_size_i,
  input  logic [ila_pkg::ADDR_W-1:0]    block_addr_i,
  input  logic                          rsp_ready_i,
  output logic                          rsp_valid_o,
  output logic [ila_pkg::ADDR_W-1:0]    payload_addr_o,
  output logic                          granted_o
);
  import ila_pkg::*;

  localparam int unsigned DEPTH   = HEAP_BYTES / 8;
  localparam int unsigned IW      = $clog2(DEPTH);
  localparam int unsigned AW      = $clog2(HEAP_BYTES) + 1;
  localparam int unsigned XW      = ((AW > GROW_W) ? AW : GROW_W) + 1;
  localparam bit          INIT_OK = (HEAP_BYTES - 16) >= CHUNK_RESET;

  logic [AW-1:0]      b_q, s_q, p_q, brk_q;
  logic [CHUNK_W-1:0] asize_q, chunk_q;
  logic [ADDR_W-1:0]  addr_q;
  logic               op_q, req_zero_q, pu_q;
  logic               out_valid_q;
  logic [ADDR_W-1:0]  pay_q;
  logic               gr_q;

  logic               we;
  logic [AW-1:0]      waddr, raddr, wdata;
  logic [AW-1:0]      rdata, rsize;
  logic               rused;
  logic [CHUNK_W-1:0] grow_max, asize_in;
  logic [GROW_W-1:0]  gsize;
  logic [AW-1:0]      asz, rest, msize;

  ila_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr[IW+2:3]),
    .wdata_i (wdata),
    .raddr_i (raddr[IW+2:3]),
    .rdata_o (rdata)
  );

  assign rsize    = rdata & ~AW'(7);
  assign rused    = rdata[0];
  assign asize_in = CHUNK_W'(({1'b0, req_size_i} + 17'(TAG_BYTES + 7)) & ~17'd7);
  assign grow_max = (chunk_q > asize_q) ? chunk_q : asize_q;
  assign gsize    = ({1'b0, grow_max} + GROW_W'(7)) & ~GROW_W'(7);
  assign asz      = AW'(asize_q);
  assign rest     = s_q - asz;
  assign msize    = s_q + (rused ? '0 : rsize) + (pu_q ? '0 : p_q);

  always_comb begin
    st_o.is_free   = op_q == OP_FREE;
    st_o.req_zero  = req_zero_q;
    st_o.addr_zero = addr_q == '0;
    st_o.at_end    = b_q >= brk_q;
    st_o.size_zero = rsize == '0;
    st_o.fit       = (XW'(rsize) >= XW'(asize_q)) && !rused;
    st_o.used      = rused;
    st_o.hit       = (XW'(b_q) + XW'(8)) == XW'(addr_q);
    st_o.past      = (XW'(b_q) + XW'(8)) > XW'(addr_q);
    st_o.split     = XW'(s_q) >= (XW'(asize_q) + XW'(MIN_SPLIT));
    st_o.no_room   = XW'(gsize) > (XW'(HEAP_BYTES) - XW'(brk_q));
    st_o.both_used = pu_q && rused;
    st_o.out_free  = !out_valid_q || rsp_ready_i;
  end

  // Memory port selection per command.
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    raddr = b_q;
    case (cmd_i)
      DP_INIT_PRO: begin we = 1'b1; waddr = '0; wdata = AW'(9); end
      DP_INIT_HDR: begin
        we = 1'b1; waddr = AW'(8);
        wdata = INIT_OK ? AW'(CHUNK_RESET) : AW'(1);
      end
      DP_INIT_FTR: begin
        we = 1'b1;
        waddr = INIT_OK ? AW'(CHUNK_RESET) : AW'(8);
        wdata = INIT_OK ? AW'(CHUNK_RESET) : AW'(1);
      end
      DP_INIT_EPI: begin
        we = 1'b1; waddr = INIT_OK ? AW'(CHUNK_RESET + 8) : AW'(8); wdata = AW'(1);
      end
      DP_WR_HDR_FREE: begin we = 1'b1; waddr = b_q;                wdata = s_q; end
      DP_WR_FTR_FREE: begin we = 1'b1; waddr = b_q + s_q - AW'(8); wdata = s_q; end
      DP_WR_HDR_USED: begin we = 1'b1; waddr = b_q;                wdata = s_q | AW'(1); end
      DP_WR_FTR_USED: begin we = 1'b1; waddr = b_q + s_q - AW'(8); wdata = s_q | AW'(1); end
      DP_WR_EPI:      begin we = 1'b1; waddr = b_q + s_q;          wdata = AW'(1); end
      DP_SPL_H:       begin we = 1'b1; waddr = b_q;                wdata = asz | AW'(1); end
      DP_SPL_F:       begin we = 1'b1; waddr = b_q + asz - AW'(8); wdata = asz | AW'(1); end
      DP_SPL_RH:      begin we = 1'b1; waddr = b_q + asz;          wdata = rest; end
      DP_SPL_RF:      begin we = 1'b1; waddr = b_q + s_q - AW'(8); wdata = rest; end
      DP_RD_PF:       raddr = b_q - AW'(8);
      DP_RD_PH:       raddr = b_q - rsize;
      DP_RD_NH:       raddr = b_q + s_q;
      default:        raddr = b_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      brk_q       <= INIT_OK ? AW'(CHUNK_RESET + 16) : AW'(16);
      chunk_q     <= CHUNK_W'(CHUNK_RESET);
      out_valid_q <= 1'b0;
      op_q        <= OP_ALLOC;
    end else begin
      if (cfg_we_i) begin
        chunk_q <= cfg_wdata_i;
      end
      if (cmd_i == DP_LOAD) begin
        op_q <= op_i;
      end
      if (cmd_i == DP_GROW) begin
        brk_q <= brk_q + AW'(gsize);
      end
      if (cmd_i == DP_RESP_OK || cmd_i == DP_RESP_NULL) begin
        out_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i)
      DP_LOAD: begin
        addr_q     <= block_addr_i;
        asize_q    <= asize_in;
        req_zero_q <= req_size_i == '0;
        b_q        <= AW'(8);
      end
      DP_STEP:  b_q <= b_q + rsize;
      DP_TAKE:  s_q <= rsize;
      DP_GROW: begin
        b_q <= brk_q - AW'(8);
        s_q <= AW'(gsize);
      end
      DP_RD_PH: p_q  <= rsize;
      DP_RD_NH: pu_q <= rused;
      DP_MCALC: begin
        if (!(pu_q && rused)) begin
          s_q <= msize;
          if (!pu_q) begin
            b_q <= b_q - p_q;
          end
        end
      end
      DP_RESP_OK: begin
        pay_q <= ADDR_W'(b_q + AW'(8));
        gr_q  <= 1'b1;
      end
      DP_RESP_NULL: begin
        pay_q <= '0;
        gr_q  <= 1'b0;
      end
      default: ;
    endcase
  end

  assign rsp_valid_o    = out_valid_q;
  assign payload_addr_o = pay_q;
  assign granted_o      = gr_q;
endmodule

### tb/sv/heap_alloc_checker.sv
// ----------------------------------------------------------------------------
// heap_alloc_checker
// Watches the request and result channels of the heap allocator, keeps its
// own boundary-tag heap image, predicts every result and compares it.
// ----------------------------------------------------------------------------
module heap_alloc_checker #(
  parameter int unsigned HEAP_BYTES = 65536
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [ila_pkg::CHUNK_W-1:0] cfg_wdata_i,
  ila_req_if.sink                     req_mon,
  ila_rsp_if.sink                     rsp_mon,
  output int                          fail_count,
  output int                          pending_count
);
  import ila_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WORDS = HEAP_BYTES / 8;

  typedef struct packed {
    logic [ADDR_W-1:0] payload_addr;
    logic              granted;
  } grant_t;

  logic [31:0] heap_img [WORDS];
  logic [31:0] brk;
  logic [31:0] chunk;
  grant_t      grants_due [$];

  function automatic logic [31:0] peek(logic [31:0] a);
    return heap_img[(a / 8) % WORDS];
  endfunction

  function automatic void poke(logic [31:0] a, logic [31:0] v);
    heap_img[(a / 8) % WORDS] = v;
  endfunction

  function automatic void tag_block(logic [31:0] b, logic [31:0] sz, logic u);
    poke(b, sz | u);
    poke(b + sz - 8, sz | u);
  endfunction

  function automatic logic [31:0] coalesce(logic [31:0] b);
    logic [31:0] sz, prv, nxt;
    logic pu, nu;
    sz  = peek(b) & ~32'd7;
    prv = b - (peek(b - 8) & ~32'd7);
    nxt = b + sz;
    pu  = |(peek(prv) & 32'd1);
    nu  = |(peek(nxt) & 32'd1);
    if (pu && nu) return b;
    if (!nu) sz += peek(nxt) & ~32'd7;
    if (!pu) begin
      sz += peek(prv) & ~32'd7;
      b = prv;
    end
    tag_block(b, sz, 1'b0);
    return b;
  endfunction

  function automatic logic [31:0] extend(logic [31:0] sz);
    logic [31:0] b;
    sz = (sz + 7) & ~32'd7;
    if (sz > HEAP_BYTES - brk) return 0;
    b = brk - 8;
    tag_block(b, sz, 1'b0);
    poke(b + sz, 1);
    brk += sz;
    return coalesce(b);
  endfunction

  function automatic logic [31:0] locate_fit(logic [31:0] asz);
    logic [31:0] b, s;
    b = 8;
    while (b < brk) begin
      s = peek(b) & ~32'd7;
      if (s == 0) break;
      if (s >= asz && (peek(b) & 32'd1) == 0) return b;
      b += s;
    end
    return 0;
  endfunction

  function automatic void release_block(logic [31:0] a);
    logic [31:0] b, s;
    b = 8;
    if (a == 0) return;
    while (b < brk) begin
      s = peek(b) & ~32'd7;
      if (s == 0) return;
      if (b + 8 == a) begin
        if ((peek(b) & 32'd1) != 0) begin
          tag_block(b, s, 1'b0);
          void'(coalesce(b));
        end
        return;
      end
      if (b + 8 > a) return;
      b += s;
    end
  endfunction

  function automatic grant_t serve(logic op, logic [15:0] rq, logic [15:0] ad);
    grant_t g;
    logic [31:0] asz, b, bs;
    g = '0;
    if (op == OP_FREE) begin
      release_block({16'd0, ad});
      return g;
    end
    if (rq == 0) return g;
    asz = ({16'd0, rq} + TAG_BYTES + 7) & ~32'd7;
    b = locate_fit(asz);
    if (b == 0) b = extend(chunk > asz ? chunk : asz);
    if (b != 0) begin
      bs = peek(b) & ~32'd7;
      if (bs >= MIN_SPLIT + asz) begin
        tag_block(b, asz, 1'b1);
        tag_block(b + asz, bs - asz, 1'b0);
      end else begin
        tag_block(b, bs, 1'b1);
      end
      g.payload_addr = 16'(b + 8);
      g.granted = 1'b1;
    end
    return g;
  endfunction

  assign pending_count = grants_due.size();

  always @(posedge clk_i or negedge rst_ni) begin
    grant_t exp_g;
    if (!rst_ni) begin
      foreach (heap_img[i]) heap_img[i] = '0;
      poke(0, 9);
      poke(8, 1);
      brk = 16;
      chunk = CHUNK_RESET;
      void'(extend(CHUNK_RESET));
      grants_due.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we_i) chunk = {15'd0, cfg_wdata_i};
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (grants_due.size() == 0) begin
          $display("%0t: unexpected result item addr=%0d granted=%0b", $time,
                   rsp_mon.payload_addr, rsp_mon.granted);
          fail_count <= fail_count + 1;
        end else begin
          exp_g = grants_due.pop_front();
          if (exp_g.payload_addr !== rsp_mon.payload_addr ||
              exp_g.granted !== rsp_mon.granted) begin
            $display("%0t: mismatch expected addr=%0d granted=%0b actual addr=%0d granted=%0b",
                     $time, exp_g.payload_addr, exp_g.granted,
                     rsp_mon.payload_addr, rsp_mon.granted);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (req_mon.valid && req_mon.ready)
        grants_due.push_back(serve(req_mon.op, req_mon.req_size, req_mon.block_addr));
    end
  end
endmodule

### tb/sv/implicit_list_heap_allocator_core_test.sv
// ----------------------------------------------------------------------------
// implicit_list_heap_allocator_core_test
// Drives allocate and free items into the heap allocator under several chunk
// sizes, with random idling on both channels; a checker beside the block
// predicts and compares every result item.
// ----------------------------------------------------------------------------
module implicit_list_heap_allocator_core_test;
  import ila_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CHUNK_W-1:0] cfg_wdata_i = '0;
  int fail_count, pending_count;
  bit calm;          // when set, neither side idles
  logic [15:0] live_addrs [$];

  ila_req_if req_ch ();
  ila_rsp_if rsp_ch ();

  implicit_list_heap_allocator_core dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .req_i(req_ch.sink), .rsp_o(rsp_ch.source)
  );

  heap_alloc_checker chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .req_mon(req_ch.sink), .rsp_mon(rsp_ch.sink),
    .fail_count, .pending_count
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // The receiver stalls at random, with odds of about 8 in 100, except in calm stretches.
  initial rsp_ch.ready = 1'b0;
  always @(posedge clk_i) rsp_ch.ready <= calm || ($urandom_range(99) >= 8);

  // Record granted payloads so that most frees name live blocks.
  always @(posedge clk_i)
    if (rsp_ch.valid && rsp_ch.ready && rsp_ch.granted)
      live_addrs.push_back(rsp_ch.payload_addr);

  // Present one item and hold it until the block takes it. Valid is dropped
  // by an idle cycle or a drain, or is reused at once for the next item.
  task automatic send_item(logic op, logic [15:0] sz, logic [15:0] ad);
    while (!calm && $urandom_range(99) < 8) begin
      req_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_ch.valid      <= 1'b1;
    req_ch.op         <= op;
    req_ch.req_size   <= sz;
    req_ch.block_addr <= ad;
    do @(posedge clk_i); while (!req_ch.ready);
  endtask

  // Wait until every expected result has come, then let the block settle.
  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic set_chunk(logic [CHUNK_W-1:0] v);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // A random item: mostly small allocations and frees of live blocks, with
  // some bad frees and the odd large request.
  task automatic random_item();
    int k, idx;
    logic [15:0] ad;
    k = $urandom_range(99);
    if (k < 50) begin
      send_item(OP_ALLOC, (k < 3) ? 16'($urandom) : 16'($urandom_range(1, 300)), 16'($urandom));
    end else if (k < 88 && live_addrs.size() != 0) begin
      idx = $urandom_range(live_addrs.size() - 1);
      ad = live_addrs[idx];
      live_addrs.delete(idx);
      send_item(OP_FREE, 16'($urandom), ad);
    end else begin
      send_item(OP_FREE, 16'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    int unsigned chunks [6] = '{8, 4096, 131071, 13, 0, 256};
    req_ch.valid = 1'b0;
    req_ch.op = OP_ALLOC;
    req_ch.req_size = '0;
    req_ch.block_addr = '0;
    calm = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: zero size, extremes, null, bad and double frees, heap full.
    send_item(OP_ALLOC, 16'd0, 16'd0);
    send_item(OP_ALLOC, 16'd1, 16'hFFFF);
    send_item(OP_ALLOC, 16'd8, 16'd0);
    send_item(OP_ALLOC, 16'd100, 16'd0);
    send_item(OP_FREE, 16'hFFFF, 16'd0);
    send_item(OP_FREE, 16'd0, 16'd16);
    send_item(OP_FREE, 16'd0, 16'd17);
    send_item(OP_FREE, 16'd0, 16'd40);
    send_item(OP_FREE, 16'd0, 16'd16);
    send_item(OP_FREE, 16'd0, 16'hFFFF);
    send_item(OP_ALLOC, 16'd4000, 16'd0);
    send_item(OP_ALLOC, 16'hFFFF, 16'd0);
    send_item(OP_ALLOC, 16'd30000, 16'd0);
    send_item(OP_ALLOC, 16'd30000, 16'd0);
    send_item(OP_ALLOC, 16'd30000, 16'd0);
    send_item(OP_FREE, 16'd0, 16'd48);
    send_item(OP_ALLOC, 16'd24, 16'd0);
    // Pause the sender until every result is back.
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      set_chunk(CHUNK_W'(chunks[ph]));
      calm = (ph == 2);
      for (int n = 0; n < 322; n++) random_item();
    end
    calm = 1'b0;
    drain();
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #500ms;
    $display("Regression FAIL");
    $finish;
  end
endmodule
